FILE: design/rfv_pkg.sv
// rfv_pkg: shared constants, types and codes for the rotating field vector generator.
// No dependencies.
package rfv_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int ANGLE_BITS_DEF = 16;

	// configuration port
	localparam int REG_W     = 32;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROT_MAG    = 3'd0,
		REG_PHASE_STEP = 3'd1,
		REG_STEER_MAG  = 3'd2,
		REG_STEER_ANG  = 3'd3,
		REG_HEAD_ANG   = 3'd4
	} reg_idx_t;

	// angles and Q15 values
	localparam int ANG_W  = 24;
	localparam int HANG_W = 16;
	localparam int Q_W    = 16;
	localparam int FQ     = 15;
	localparam int MAG_W  = 15;
	localparam int RS_W   = 2 * Q_W - 1;

	localparam logic [ANG_W-1:0] QUARTER = 24'h40_0000;
	localparam logic [Q_W-1:0]   U_ONE   = 16'h8000;
	localparam logic [Q_W-1:0]   SIN_A   = 16'd51437;
	localparam logic [Q_W-1:0]   SIN_B   = 16'd20953;
	localparam logic [Q_W-1:0]   SIN_C   = 16'd2285;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;
	localparam logic [Q_W-1:0]   Q_MAX   = 16'h7FFF;
	localparam logic [Q_W-1:0]   Q_MIN   = 16'h8000;

	// serial multiplier
	localparam int MA_W  = 32;
	localparam int MB_W  = 16;
	localparam int D_W   = 4;
	localparam int P_W   = MA_W + MB_W;
	localparam int SUM_W = MA_W + D_W;
	localparam int STEPS = MB_W / D_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	// Q45 -> Q15 rounding
	localparam int RND_SH = 30;
	localparam int R_W    = P_W - RND_SH;
	localparam logic [P_W-1:0] RND_HALF = P_W'(64'd1 << (RND_SH - 1));

	// sequencer op codes: sine ops are {angle, sub step}, then the products
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_RS = 5'd24;
	localparam logic [OP_W-1:0] OP_X1 = 5'd25;
	localparam logic [OP_W-1:0] OP_Y1 = 5'd26;
	localparam logic [OP_W-1:0] OP_X2 = 5'd27;
	localparam logic [OP_W-1:0] OP_Y2 = 5'd28;
	localparam logic [OP_W-1:0] OP_Z  = 5'd29;

	localparam logic [1:0] SUB_SQ = 2'd0;
	localparam logic [1:0] SUB_T1 = 2'd1;
	localparam logic [1:0] SUB_T2 = 2'd2;
	localparam logic [1:0] SUB_S  = 2'd3;

	localparam int N_ANG = 6;
	localparam logic [2:0] AI_TH_S = 3'd0;
	localparam logic [2:0] AI_TH_C = 3'd1;
	localparam logic [2:0] AI_H_S  = 3'd2;
	localparam logic [2:0] AI_H_C  = 3'd3;
	localparam logic [2:0] AI_HA_S = 3'd4;
	localparam logic [2:0] AI_HA_C = 3'd5;

	localparam logic [1:0] BASE_TH = 2'd0;
	localparam logic [1:0] BASE_H  = 2'd1;
	localparam logic [1:0] BASE_HA = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_ROUND
	} core_state_t;

	typedef struct packed {
		logic            start;
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic           done;
		logic [P_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic signed [Q_W-1:0] rmag;
		logic signed [Q_W-1:0] smag;
		logic [ANG_W-1:0]      h24;
		logic [ANG_W-1:0]      ha24;
	} core_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

endpackage

FILE: design/rotating_field_vector_generator_top.sv
// Rotating field vector generator: phase accumulator, config registers, output register.
// Each input word runs 30 multiplies in turn on a single 4-bit-per-cycle shift-add
// multiplier (issue, then wait for done), then a round state that holds until the output
// slot is free; in_stall stays high meanwhile, so a word is done before the next is taken.
// Reset (arst_n low): all config registers and the phase clear to zero, no output word.
// Depends on rfv_pkg and rfv_core.
module rotating_field_vector_generator_top #(
	parameter int PHASE_BITS = rfv_pkg::PHASE_BITS_DEF,
	parameter int ANGLE_BITS = rfv_pkg::ANGLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rfv_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [rfv_pkg::REG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [rfv_pkg::Q_W-1:0]  field_x,
	output logic signed [rfv_pkg::Q_W-1:0]  field_y,
	output logic signed [rfv_pkg::Q_W-1:0]  field_z
);
	import rfv_pkg::*;

	localparam int TH_DN  = (PHASE_BITS >= ANGLE_BITS) ? PHASE_BITS - ANGLE_BITS : 0;
	localparam int TH_UP  = (PHASE_BITS >= ANGLE_BITS) ? 0 : ANGLE_BITS - PHASE_BITS;
	localparam int TH_PAD = ANG_W - ANGLE_BITS;

	logic signed [Q_W-1:0] rot_mag_q, steer_mag_q;
	logic [REG_W-1:0]      phase_step_q;
	logic [HANG_W-1:0]     steer_ang_q, head_ang_q;
	logic [PHASE_BITS-1:0] phase_q, phase_p;
	logic [ANGLE_BITS-1:0] theta;
	logic [ANG_W-1:0]      th24;
	logic [HANG_W-1:0]     ha16;
	logic                  accept, slot_free;
	logic                  out_valid_q;
	logic signed [Q_W-1:0] fx_q, fy_q, fz_q;
	logic signed [Q_W-1:0] fx, fy, fz;
	core_cfg_t             ccfg;
	core_stat_t            stat;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = stat.busy;

	always_comb begin
		phase_p = restart ? '0 : phase_q;
		theta   = ANGLE_BITS'(phase_p >> TH_DN) << TH_UP;
		th24    = ANG_W'(theta) << TH_PAD;
		ha16    = head_ang_q + steer_ang_q;
		ccfg.rmag = rot_mag_q;
		ccfg.smag = steer_mag_q;
		ccfg.h24  = {head_ang_q, (ANG_W - HANG_W)'(0)};
		ccfg.ha24 = {ha16, (ANG_W - HANG_W)'(0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_mag_q    <= '0;
			phase_step_q <= '0;
			steer_mag_q  <= '0;
			steer_ang_q  <= '0;
			head_ang_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROT_MAG:    rot_mag_q    <= cfg_data[Q_W-1:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_STEER_MAG:  steer_mag_q  <= cfg_data[Q_W-1:0];
				REG_STEER_ANG:  steer_ang_q  <= cfg_data[HANG_W-1:0];
				REG_HEAD_ANG:   head_ang_q   <= cfg_data[HANG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_p + PHASE_BITS'(phase_step_q);
			end
			if (stat.done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			fx_q <= fx;
			fy_q <= fy;
			fz_q <= fz;
		end
	end

	rfv_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.th24     (th24),
		.cfg      (ccfg),
		.slot_free(slot_free),
		.stat     (stat),
		.fx       (fx),
		.fy       (fy),
		.fz       (fz)
	);

	assign out_valid = out_valid_q;
	assign field_x   = fx_q;
	assign field_y   = fy_q;
	assign field_z   = fz_q;

	a_restart_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> phase_q == $past(PHASE_BITS'(phase_step_q)))
		else $error("phase not restarted");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> slot_free)
		else $error("output word overwritten");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("core not busy after accept");

endmodule

FILE: design/rfv_smul.sv
// rfv_smul: unsigned shift-add multiplier, one 4-bit digit of b per cycle.
// Depends on rfv_pkg.
module rfv_smul (
	input  logic              clk,
	input  logic              arst_n,
	input  rfv_pkg::mul_req_t req,
	output rfv_pkg::mul_rsp_t rsp
);
	import rfv_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [MA_W-1:0]  a_q;
	logic [P_W-1:0]   p_q;
	logic [SUM_W-1:0] sum;

	assign sum = SUM_W'(p_q[P_W-1:MB_W]) + SUM_W'(a_q) * SUM_W'(p_q[D_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			p_q <= P_W'(req.b);
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[MB_W-1:D_W]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> !req.start)
		else $error("multiply started while busy");

	a_done_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##(STEPS + 1) rsp.done)
		else $error("product not ready on time");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("done longer than one cycle");

endmodule

FILE: design/rfv_core.sv
// rfv_core: op sequencer for sines and field products on one serial multiplier.
// Depends on rfv_pkg and rfv_smul.
module rfv_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rfv_pkg::ANG_W-1:0]   th24,
	input  rfv_pkg::core_cfg_t          cfg,
	input  logic                        slot_free,
	output rfv_pkg::core_stat_t         stat,
	output logic signed [rfv_pkg::Q_W-1:0] fx,
	output logic signed [rfv_pkg::Q_W-1:0] fy,
	output logic signed [rfv_pkg::Q_W-1:0] fz
);
	import rfv_pkg::*;

	core_state_t state_q, state_d;
	logic [OP_W-1:0] op_q;

	logic [ANG_W-1:0]  th24_q;
	logic [Q_W-1:0]    u2_q;
	logic [Q_W-1:0]    t_q;
	logic [MAG_W-1:0]  mag_q [N_ANG];
	logic              sgn_q [N_ANG];
	logic [RS_W-1:0]   rs_q;
	logic              rs_neg_q;
	logic signed [P_W-1:0] acc_x_q, acc_y_q, acc_z_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	logic [2:0]       ang_idx;
	logic [1:0]       sub;
	logic             is_sin;
	logic [ANG_W-1:0] base, ang;
	logic [1:0]       quad;
	logic [Q_W-1:0]   u;
	logic             rm_neg, sm_neg;
	logic [Q_W-1:0]   rm_mag, sm_mag;
	logic             neg, sh15, wb;
	logic             mul_go;
	logic [P_W-1:0]   prod_sh;
	logic signed [P_W-1:0] term;

	function automatic logic signed [Q_W-1:0] rnd_sat(input logic signed [P_W-1:0] v);
		logic signed [P_W-1:0] s;
		logic [R_W-1:0]        r;
		logic signed [Q_W-1:0] o;
		s = v + $signed(RND_HALF);
		r = s[P_W-1:RND_SH];
		if (r[R_W-1:Q_W-1] == '0 || &r[R_W-1:Q_W-1]) begin
			o = r[Q_W-1:0];
		end else if (r[R_W-1]) begin
			o = Q_MIN;
		end else begin
			o = Q_MAX;
		end
		return o;
	endfunction

	rfv_smul u_smul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rsp   (mrsp)
	);

	// sine angle and quadrant position
	always_comb begin
		ang_idx = op_q[4:2];
		sub     = op_q[1:0];
		is_sin  = (op_q < OP_RS);
		case (ang_idx[2:1])
			BASE_TH: base = th24_q;
			BASE_H:  base = cfg.h24;
			BASE_HA: base = cfg.ha24;
			default: base = th24_q;
		endcase
		ang  = base + (ang_idx[0] ? QUARTER : '0);
		quad = ang[ANG_W-1:ANG_W-2];
		u    = quad[0] ? (U_ONE - {1'b0, ang[ANG_W-3:ANG_W-2-MAG_W]})
		               : {1'b0, ang[ANG_W-3:ANG_W-2-MAG_W]};
		rm_neg = cfg.rmag[Q_W-1];
		sm_neg = cfg.smag[Q_W-1];
		rm_mag = rm_neg ? (~cfg.rmag + Q_W'(1)) : cfg.rmag;
		sm_mag = sm_neg ? (~cfg.smag + Q_W'(1)) : cfg.smag;
	end

	// multiplier operands and term sign per op
	always_comb begin
		mreq.start = mul_go;
		mreq.a = '0;
		mreq.b = '0;
		neg    = 1'b0;
		sh15   = 1'b0;
		if (is_sin) begin
			case (sub)
				SUB_SQ: begin
					mreq.a = MA_W'(u);
					mreq.b = u;
				end
				SUB_T1: begin
					mreq.a = MA_W'(u2_q);
					mreq.b = SIN_C;
				end
				SUB_T2: begin
					mreq.a = MA_W'(u2_q);
					mreq.b = t_q;
				end
				SUB_S: begin
					mreq.a = MA_W'(u);
					mreq.b = t_q;
				end
			endcase
		end else begin
			case (op_q)
				OP_RS: begin
					mreq.a = MA_W'(rm_mag);
					mreq.b = {1'b0, mag_q[AI_TH_S]};
				end
				OP_X1: begin
					mreq.a = MA_W'(rs_q);
					mreq.b = {1'b0, mag_q[AI_H_C]};
					neg    = rs_neg_q ^ sgn_q[AI_H_C];
				end
				OP_Y1: begin
					mreq.a = MA_W'(rs_q);
					mreq.b = {1'b0, mag_q[AI_H_S]};
					neg    = rs_neg_q ^ sgn_q[AI_H_S];
				end
				OP_X2: begin
					mreq.a = MA_W'(sm_mag);
					mreq.b = {1'b0, mag_q[AI_HA_C]};
					neg    = sm_neg ^ sgn_q[AI_HA_C];
					sh15   = 1'b1;
				end
				OP_Y2: begin
					mreq.a = MA_W'(sm_mag);
					mreq.b = {1'b0, mag_q[AI_HA_S]};
					neg    = sm_neg ^ sgn_q[AI_HA_S];
					sh15   = 1'b1;
				end
				OP_Z: begin
					mreq.a = MA_W'(rm_mag);
					mreq.b = {1'b0, mag_q[AI_TH_C]};
					neg    = rm_neg ^ sgn_q[AI_TH_C];
					sh15   = 1'b1;
				end
				default: ;
			endcase
		end
		prod_sh = sh15 ? (mrsp.p << FQ) : mrsp.p;
		term    = neg ? -$signed(prod_sh) : $signed(prod_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				op_q <= '0;
			end else if (wb) begin
				op_q <= op_q + OP_W'(1);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_go     = 1'b0;
		stat.done  = 1'b0;
		wb         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				mul_go  = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (mrsp.done) begin
					wb      = 1'b1;
					state_d = (op_q == OP_Z) ? ST_ROUND : ST_ISSUE;
				end
			end
			ST_ROUND: begin
				if (slot_free) begin
					stat.done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		stat.busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			th24_q <= th24;
		end
		if (wb) begin
			if (is_sin) begin
				case (sub)
					SUB_SQ: u2_q <= mrsp.p[FQ +: Q_W];
					SUB_T1: t_q  <= SIN_B - mrsp.p[FQ +: Q_W];
					SUB_T2: t_q  <= SIN_A - mrsp.p[FQ +: Q_W];
					SUB_S: begin
						mag_q[ang_idx] <= mrsp.p[2 * FQ] ? MAG_MAX : mrsp.p[FQ +: MAG_W];
						sgn_q[ang_idx] <= quad[1];
					end
				endcase
			end else begin
				case (op_q)
					OP_RS: begin
						rs_q     <= mrsp.p[RS_W-1:0];
						rs_neg_q <= rm_neg ^ sgn_q[AI_TH_S];
					end
					OP_X1: acc_x_q <= term;
					OP_Y1: acc_y_q <= term;
					OP_X2: acc_x_q <= acc_x_q + term;
					OP_Y2: acc_y_q <= acc_y_q + term;
					OP_Z:  acc_z_q <= term;
					default: ;
				endcase
			end
		end
	end

	assign fx = rnd_sat(acc_x_q);
	assign fy = rnd_sat(acc_y_q);
	assign fz = rnd_sat(acc_z_q);

endmodule
